// File: rtl/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg
// Shared constants, operation codes and controller/datapath interface types
// for the file block allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int unsigned FILES_DEF      = 16;
  localparam int unsigned DEVICES_DEF    = 4;
  localparam int unsigned BLOCKS_DEF     = 64;
  localparam int unsigned PAGE_BYTES_DEF = 256;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned POS_W     = 14;
  localparam int unsigned PAGE_W    = 10;
  localparam int unsigned DEV_OUT_W = 2;
  localparam int unsigned BLK_OUT_W = 6;
  localparam int unsigned LEN_W     = POS_W + 1;
  localparam int unsigned OC_W      = 8;

  localparam logic [OC_W-1:0] OPEN_MAX = 8'd255;

  localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
  localparam logic [OP_W-1:0] OP_OPEN   = 3'd1;
  localparam logic [OP_W-1:0] OP_CLOSE  = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_init;
    logic slot_inc;
    logic create_fail;
    logic dev_init;
    logic dev_step;
    logic create;
    logic do_open;
    logic do_close;
    logic alloc_init;
    logic alloc_step;
    logic wr_commit;
    logic map_take;
    logic rel_step;
    logic rel_commit;
    logic emit;
  } fba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_create;
    logic is_open;
    logic is_close;
    logic is_read;
    logic is_write;
    logic live;
    logic close_frees;
    logic slot_free;
    logic slot_last;
    logic dev_last;
    logic rd_ok;
    logic wr_ok;
    logic need_zero;
    logic alloc_last;
    logic rel_done;
    logic out_free;
  } fba_stat_t;

endpackage

// File: rtl/fba_ram.sv
// ----------------------------------------------------------------------------
// fba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/fba_dp.sv
// ----------------------------------------------------------------------------
// fba_dp
// Datapath: directory tables, free counts, block map and free bitmap RAMs,
// page index, sweep counters and the result register.
// ----------------------------------------------------------------------------
module fba_dp import fba_pkg::*; #(
  parameter int unsigned FILES      = FILES_DEF,
  parameter int unsigned DEVICES    = DEVICES_DEF,
  parameter int unsigned BLOCKS     = BLOCKS_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fba_cmd_t             cmd_i,
  output fba_stat_t            stat_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [SLOT_W-1:0]    file_slot_i,
  input  logic [POS_W-1:0]     position_i,
  input  logic [PAGE_W-1:0]    page_id_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic                 status_o,
  output logic [SLOT_W-1:0]    slot_out_o,
  output logic [DEV_OUT_W-1:0] device_o,
  output logic [BLK_OUT_W-1:0] block_o,
  output logic [PAGE_W-1:0]    page_out_o
);

  localparam int unsigned FILE_W    = $clog2(FILES);
  localparam int unsigned DEV_W     = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int unsigned BLK_W     = $clog2(BLOCKS);
  localparam int unsigned CNT_W     = $clog2(BLOCKS + 1);
  localparam int unsigned MAP_DEPTH = FILES * BLOCKS;
  localparam int unsigned MAP_AW    = $clog2(MAP_DEPTH);
  localparam int unsigned BM_DEPTH  = DEVICES * BLOCKS;
  localparam int unsigned BM_AW     = $clog2(BM_DEPTH);
  localparam int unsigned PG_SH     = $clog2(PAGE_BYTES);
  localparam int unsigned LG1_W     = POS_W + 1;

  // item
  logic [OP_W-1:0]      op_q;
  logic [SLOT_W-1:0]    slot_in_q;
  logic [POS_W-1:0]     pos_q;
  logic [PAGE_W-1:0]    page_q;
  logic [FILE_W-1:0]    idx_q;

  // result under construction and output register
  logic                 res_status_q;
  logic [SLOT_W-1:0]    res_slot_q;
  logic [DEV_OUT_W-1:0] res_dev_q;
  logic [BLK_OUT_W-1:0] res_blk_q;
  logic                 out_valid_q;
  logic                 out_status_q;
  logic [SLOT_W-1:0]    out_slot_q;
  logic [DEV_OUT_W-1:0] out_dev_q;
  logic [BLK_OUT_W-1:0] out_blk_q;
  logic [PAGE_W-1:0]    out_page_q;

  // directory
  logic                 slot_used_q [FILES];
  logic [DEV_W-1:0]     fdev_q      [FILES];
  logic [LEN_W-1:0]     flen_q      [FILES];
  logic [OC_W-1:0]      focnt_q     [FILES];
  logic [CNT_W-1:0]     fnblk_q     [FILES];
  logic [CNT_W-1:0]     fc_q        [DEVICES];

  // device scan
  logic [DEV_W-1:0]     dcnt_q;
  logic [DEV_W-1:0]     best_q;
  logic [CNT_W-1:0]     most_q;

  // logical block of the position, page size is a power of two
  logic [POS_W-1:0]     quo;

  // sweeps
  logic [CNT_W-1:0]     scan_q;
  logic                 pend_q;
  logic [BLK_W-1:0]     rd_idx_q;
  logic [CNT_W-1:0]     lptr_q;
  logic [CNT_W-1:0]     remain_q;
  logic                 bm_vld_q [BM_DEPTH];
  logic [BM_AW-1:0]     bm_raddr_q;

  logic [DEV_W-1:0]     cur_dev;
  logic [LEN_W-1:0]     cur_len;
  logic [OC_W-1:0]      cur_oc;
  logic [CNT_W-1:0]     cur_nblk;
  logic [DEV_W-1:0]     fc_ridx;
  logic [CNT_W-1:0]     fc_rd;
  logic                 lg_in;
  logic [LG1_W-1:0]     lg1;
  logic [LG1_W-1:0]     need_full;
  logic [CNT_W-1:0]     need;
  logic                 bm_used;
  logic                 grab;
  logic                 issue_alloc;
  logic                 issue_rel;
  logic                 map_we;
  logic [MAP_AW-1:0]    map_waddr;
  logic [MAP_AW-1:0]    map_raddr;
  logic [BLK_W-1:0]     map_rdata;
  logic                 bm_we;
  logic [BM_AW-1:0]     bm_waddr;
  logic                 bm_wdata;
  logic [BM_AW-1:0]     bm_raddr_d;
  logic                 bm_rdata;

  assign cur_dev  = fdev_q[idx_q];
  assign cur_len  = flen_q[idx_q];
  assign cur_oc   = focnt_q[idx_q];
  assign cur_nblk = fnblk_q[idx_q];
  assign fc_ridx  = cmd_i.dev_step ? dcnt_q : cur_dev;
  assign fc_rd    = fc_q[fc_ridx];

  assign quo       = pos_q >> PG_SH;
  assign lg_in     = 32'(quo) < BLOCKS;
  assign lg1       = LG1_W'(quo) + LG1_W'(1);
  assign need_full = (lg1 > LG1_W'(cur_nblk)) ? lg1 - LG1_W'(cur_nblk) : '0;
  assign need      = CNT_W'(need_full);

  assign bm_used     = bm_vld_q[bm_raddr_q] & bm_rdata;
  assign grab        = cmd_i.alloc_step && pend_q && !bm_used && (remain_q != '0);
  assign issue_alloc = cmd_i.alloc_step && (32'(scan_q) < BLOCKS);
  assign issue_rel   = cmd_i.rel_step && (scan_q < cur_nblk);

  assign map_we    = grab;
  assign map_waddr = MAP_AW'(32'(idx_q) * BLOCKS + 32'(lptr_q));
  assign map_raddr = cmd_i.rel_step ? MAP_AW'(32'(idx_q) * BLOCKS + 32'(scan_q))
                                    : MAP_AW'(32'(idx_q) * BLOCKS + 32'(quo));

  // allocation marks used, release marks free
  assign bm_we      = grab || (cmd_i.rel_step && pend_q);
  assign bm_waddr   = grab ? BM_AW'(32'(cur_dev) * BLOCKS + 32'(rd_idx_q))
                           : BM_AW'(32'(cur_dev) * BLOCKS + 32'(map_rdata));
  assign bm_wdata   = grab;
  assign bm_raddr_d = BM_AW'(32'(cur_dev) * BLOCKS + 32'(scan_q));

  fba_ram #(
    .WIDTH (BLK_W),
    .DEPTH (MAP_DEPTH)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (rd_idx_q),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  fba_ram #(
    .WIDTH (1),
    .DEPTH (BM_DEPTH)
  ) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .raddr_i (bm_raddr_d),
    .rdata_o (bm_rdata)
  );

  always_comb begin
    stat_o             = '0;
    stat_o.is_create   = op_q == OP_CREATE;
    stat_o.is_open     = op_q == OP_OPEN;
    stat_o.is_close    = op_q == OP_CLOSE;
    stat_o.is_read     = op_q == OP_READ;
    stat_o.is_write    = op_q == OP_WRITE;
    stat_o.live        = (32'(slot_in_q) < FILES) && slot_used_q[idx_q];
    stat_o.close_frees = cur_oc <= OC_W'(1);
    stat_o.slot_free   = !slot_used_q[idx_q];
    stat_o.slot_last   = 32'(idx_q) == FILES - 1;
    stat_o.dev_last    = 32'(dcnt_q) == DEVICES - 1;
    stat_o.rd_ok       = (pos_q != '0) && (LEN_W'(pos_q) < cur_len) && lg_in;
    stat_o.wr_ok       = (pos_q != '0) && lg_in && (need <= fc_rd);
    stat_o.need_zero   = need == '0;
    stat_o.alloc_last  = grab && (remain_q == CNT_W'(1));
    stat_o.rel_done    = (scan_q >= cur_nblk) && !pend_q;
    stat_o.out_free    = !out_valid_q || out_ready_i;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      for (int i = 0; i < FILES; i++) begin
        slot_used_q[i] <= 1'b0;
      end
      for (int d = 0; d < DEVICES; d++) begin
        fc_q[d] <= CNT_W'(BLOCKS);
      end
      for (int b = 0; b < BM_DEPTH; b++) begin
        bm_vld_q[b] <= 1'b0;
      end
    end else begin
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.do_close || cmd_i.alloc_init) begin
        pend_q <= 1'b0;
      end else if (cmd_i.alloc_step) begin
        pend_q <= issue_alloc;
      end else if (cmd_i.rel_step) begin
        pend_q <= issue_rel;
      end
      if (cmd_i.create) begin
        slot_used_q[idx_q] <= 1'b1;
      end else if (cmd_i.rel_commit) begin
        slot_used_q[idx_q] <= 1'b0;
      end
      if (cmd_i.wr_commit) begin
        fc_q[cur_dev] <= fc_rd - need;
      end else if (cmd_i.rel_commit) begin
        fc_q[cur_dev] <= fc_rd + cur_nblk;
      end
      if (bm_we) begin
        bm_vld_q[bm_waddr] <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q         <= op_i;
      slot_in_q    <= file_slot_i;
      pos_q        <= position_i;
      page_q       <= page_id_i;
      idx_q        <= FILE_W'(file_slot_i);
      res_status_q <= 1'b1;
      res_slot_q   <= file_slot_i;
      res_dev_q    <= '0;
      res_blk_q    <= '0;
    end
    if (cmd_i.scan_init) begin
      idx_q <= '0;
    end else if (cmd_i.slot_inc) begin
      idx_q <= idx_q + FILE_W'(1);
    end
    if (cmd_i.create_fail) begin
      res_slot_q <= '0;
    end
    if (cmd_i.dev_init) begin
      dcnt_q <= '0;
      best_q <= '0;
      most_q <= '0;
    end else if (cmd_i.dev_step) begin
      dcnt_q <= dcnt_q + DEV_W'(1);
      if (fc_rd >= most_q) begin
        best_q <= dcnt_q;
        most_q <= fc_rd;
      end
    end
    if (cmd_i.create) begin
      fdev_q[idx_q]  <= best_q;
      flen_q[idx_q]  <= '0;
      focnt_q[idx_q] <= '0;
      fnblk_q[idx_q] <= '0;
      res_status_q   <= 1'b0;
      res_slot_q     <= SLOT_W'(idx_q);
      res_dev_q      <= DEV_OUT_W'(best_q);
    end
    if (cmd_i.do_open) begin
      if (cur_oc < OPEN_MAX) begin
        focnt_q[idx_q] <= cur_oc + OC_W'(1);
      end
      res_status_q <= 1'b0;
      res_dev_q    <= DEV_OUT_W'(cur_dev);
    end
    if (cmd_i.do_close) begin
      if (cur_oc != '0) begin
        focnt_q[idx_q] <= cur_oc - OC_W'(1);
      end
      res_status_q <= 1'b0;
      res_dev_q    <= DEV_OUT_W'(cur_dev);
      scan_q       <= '0;
    end
    if (cmd_i.alloc_init) begin
      scan_q   <= '0;
      lptr_q   <= cur_nblk;
      remain_q <= need;
    end else if (cmd_i.alloc_step) begin
      if (issue_alloc) begin
        scan_q     <= scan_q + CNT_W'(1);
        rd_idx_q   <= BLK_W'(scan_q);
        bm_raddr_q <= bm_raddr_d;
      end
      if (grab) begin
        lptr_q   <= lptr_q + CNT_W'(1);
        remain_q <= remain_q - CNT_W'(1);
      end
    end
    if (cmd_i.rel_step && issue_rel) begin
      scan_q <= scan_q + CNT_W'(1);
    end
    if (cmd_i.wr_commit) begin
      fnblk_q[idx_q] <= cur_nblk + need;
      if (cur_len <= LEN_W'(pos_q)) begin
        flen_q[idx_q] <= LEN_W'(pos_q) + LEN_W'(1);
      end
    end
    if (cmd_i.map_take) begin
      res_status_q <= 1'b0;
      res_dev_q    <= DEV_OUT_W'(cur_dev);
      res_blk_q    <= BLK_OUT_W'(map_rdata);
    end
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_dev_q    <= res_dev_q;
      out_blk_q    <= res_blk_q;
      out_page_q   <= page_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign slot_out_o  = out_slot_q;
  assign device_o    = out_dev_q;
  assign block_o     = out_blk_q;
  assign page_out_o  = out_page_q;

  // a device never counts more free blocks than it has
  a_free_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fc_rd) <= BLOCKS)
    else $error("free count above block count");

  // the allocation sweep must find every block it needs before running off the end
  a_alloc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.alloc_step && !pend_q) |-> (32'(scan_q) < BLOCKS))
    else $error("allocation sweep ran past the last block");

endmodule

// File: rtl/fba_ctrl.sv
// ----------------------------------------------------------------------------
// fba_ctrl
// Controller: sequences one operation at a time through the datapath.
// ----------------------------------------------------------------------------
module fba_ctrl import fba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  fba_stat_t stat_i,
  output fba_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_SLOT   = 4'd2;
  localparam logic [3:0] S_DEVSC  = 4'd3;
  localparam logic [3:0] S_CREATE = 4'd4;
  localparam logic [3:0] S_CHECK  = 4'd6;
  localparam logic [3:0] S_ALLOC  = 4'd7;
  localparam logic [3:0] S_WRFIN  = 4'd8;
  localparam logic [3:0] S_MAPRD  = 4'd9;
  localparam logic [3:0] S_REL    = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0] state_q;
  logic [3:0] state_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        if (stat_i.is_create) begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SLOT;
        end else if (stat_i.live && stat_i.is_open) begin
          cmd_o.do_open = 1'b1;
          state_d       = S_DONE;
        end else if (stat_i.live && stat_i.is_close) begin
          cmd_o.do_close = 1'b1;
          state_d        = stat_i.close_frees ? S_REL : S_DONE;
        end else if (stat_i.live && (stat_i.is_read || stat_i.is_write)) begin
          state_d = S_CHECK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SLOT: begin
        if (stat_i.slot_free) begin
          cmd_o.dev_init = 1'b1;
          state_d        = S_DEVSC;
        end else if (stat_i.slot_last) begin
          cmd_o.create_fail = 1'b1;
          state_d           = S_DONE;
        end else begin
          cmd_o.slot_inc = 1'b1;
        end
      end
      S_DEVSC: begin
        cmd_o.dev_step = 1'b1;
        if (stat_i.dev_last) begin
          state_d = S_CREATE;
        end
      end
      S_CREATE: begin
        cmd_o.create = 1'b1;
        state_d      = S_DONE;
      end
      S_CHECK: begin
        if (stat_i.is_read) begin
          state_d = stat_i.rd_ok ? S_MAPRD : S_DONE;
        end else if (!stat_i.wr_ok) begin
          state_d = S_DONE;
        end else if (stat_i.need_zero) begin
          state_d = S_WRFIN;
        end else begin
          cmd_o.alloc_init = 1'b1;
          state_d          = S_ALLOC;
        end
      end
      S_ALLOC: begin
        cmd_o.alloc_step = 1'b1;
        if (stat_i.alloc_last) begin
          state_d = S_WRFIN;
        end
      end
      S_WRFIN: begin
        cmd_o.wr_commit = 1'b1;
        state_d         = S_MAPRD;
      end
      S_MAPRD: begin
        cmd_o.map_take = 1'b1;
        state_d        = S_DONE;
      end
      S_REL: begin
        cmd_o.rel_step = 1'b1;
        if (stat_i.rel_done) begin
          cmd_o.rel_commit = 1'b1;
          state_d          = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a result only moves into the output register once it is free
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> stat_i.out_free)
    else $error("result emitted over a pending one");

  // an allocation start in the check state always leads into the sweep
  a_alloc_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK && cmd_o.alloc_init) |=> (state_q == S_ALLOC))
    else $error("allocation did not start");

endmodule

// File: rtl/file_block_allocator.sv
// ----------------------------------------------------------------------------
// file_block_allocator
// Small file directory with per-device free-block bitmaps and first-fit
// block allocation, built as a controller and a datapath.
// ----------------------------------------------------------------------------
// usage
//   - request channel (in_valid_i/in_ready_o) carries op, file_slot,
//     position and page_id; one response per request on the result channel
//     (out_valid_o/out_ready_i) with status, slot_out, device, block, page_out
//   - one request in flight at a time; in_ready_o is high while idle, even
//     when the previous response still sits in the output register
//   - steps from accept to response valid, each ending in the done state:
//       open, close that frees nothing, bad slot or unknown op: dispatch
//       create: slot scan to the first free slot, then device scan, then
//               create; directory full: slot scan over every slot
//       read: check, then map read (page index is a shift); a failed check ends it
//       write: check, commit, map read; with new blocks a first-fit
//              sweep over the bitmap, one entry per cycle, comes first
//       close that frees: release sweep over the file blocks
//     the next request can be taken as soon as the response goes valid,
//     so throughput is set by the slot, bitmap and map sweeps
//   - reset empties the directory and marks every block free; no clearing
//     pass is needed, items are taken right after reset
//   - when the receiver stalls, the finished response waits in the output
//     register and the next one waits in the controller done state
// ----------------------------------------------------------------------------
module file_block_allocator import fba_pkg::*; #(
  parameter int unsigned FILES      = FILES_DEF,
  parameter int unsigned DEVICES    = DEVICES_DEF,
  parameter int unsigned BLOCKS     = BLOCKS_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [SLOT_W-1:0]    file_slot_i,
  input  logic [POS_W-1:0]     position_i,
  input  logic [PAGE_W-1:0]    page_id_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 status_o,
  output logic [SLOT_W-1:0]    slot_out_o,
  output logic [DEV_OUT_W-1:0] device_o,
  output logic [BLK_OUT_W-1:0] block_o,
  output logic [PAGE_W-1:0]    page_out_o
);

  // command and status between sequencer and datapath
  fba_cmd_t  cmd;
  fba_stat_t stat;

  // operation sequencer
  fba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // tables, rams, page index and response register
  fba_dp #(
    .FILES      (FILES),
    .DEVICES    (DEVICES),
    .BLOCKS     (BLOCKS),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .op_i        (op_i),
    .file_slot_i (file_slot_i),
    .position_i  (position_i),
    .page_id_i   (page_id_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .slot_out_o  (slot_out_o),
    .device_o    (device_o),
    .block_o     (block_o),
    .page_out_o  (page_out_o)
  );

  // a request is only taken while no response is under construction
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while busy");

endmodule
